@@ design/pscull_pkg.sv @@
package pscull_pkg;

    localparam int unsigned COORD_W = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SPHERE = 2'd2;
    localparam logic [1:0] OP_BOX    = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] d;
    } plane_t;

    typedef struct packed {
        logic start;
        logic issue;
        logic last;
    } dist_ctrl_t;

    typedef struct packed {
        logic done;
        logic visible;
    } dist_stat_t;

endpackage

@@ design/pscull_plane_mem.sv @@
module pscull_plane_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  pscull_pkg::plane_t     wdata,
    input  logic                   re,
    input  logic [ADDR_W-1:0]      raddr,
    output pscull_pkg::plane_t     rdata
);
    import pscull_pkg::*;

    plane_t mem [DEPTH];
    plane_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/pscull_dist_unit.sv @@
module pscull_dist_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pscull_pkg::dist_ctrl_t             ctrl,
    input  logic                               box,
    input  logic signed [pscull_pkg::COORD_W-1:0] a_x,
    input  logic signed [pscull_pkg::COORD_W-1:0] a_y,
    input  logic signed [pscull_pkg::COORD_W-1:0] a_z,
    input  logic signed [pscull_pkg::COORD_W-1:0] b_x,
    input  logic signed [pscull_pkg::COORD_W-1:0] b_y,
    input  logic signed [pscull_pkg::COORD_W-1:0] b_z,
    input  logic signed [pscull_pkg::COORD_W-1:0] scalar,
    input  pscull_pkg::plane_t                 plane,
    output pscull_pkg::dist_stat_t             stat
);
    import pscull_pkg::*;

    localparam int PROD_W = 2 * COORD_W;
    localparam int OFF_W  = COORD_W + 1;

    logic                      box_reg;
    logic signed [COORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [COORD_W-1:0] neg_x_reg, neg_y_reg, neg_z_reg;
    logic signed [OFF_W-1:0]   bias_reg;

    logic v0_reg, last0_reg, v1_reg, last1_reg, v2_reg, last2_reg;
    logic done_reg, visible_reg;

    logic signed [PROD_W-1:0]  p_x_reg, p_y_reg, p_z_reg;
    logic signed [OFF_W-1:0]   off_reg;
    logic signed [PROD_W:0]    sum_a_reg, sum_b_reg;

    logic signed [COORD_W-1:0] op_x, op_y, op_z;
    logic signed [PROD_W+1:0]  total;
    logic                      culled;

    // The farthest corner along the normal uses the larger coordinate where the
    // normal component is positive and the smaller one where it is negative.
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            box_reg   <= box;
            pos_x_reg <= (box && b_x > a_x) ? b_x : a_x;
            pos_y_reg <= (box && b_y > a_y) ? b_y : a_y;
            pos_z_reg <= (box && b_z > a_z) ? b_z : a_z;
            neg_x_reg <= (box && b_x < a_x) ? b_x : a_x;
            neg_y_reg <= (box && b_y < a_y) ? b_y : a_y;
            neg_z_reg <= (box && b_z < a_z) ? b_z : a_z;
            bias_reg  <= box ? '0 : OFF_W'(scalar);
        end
    end

    assign op_x = plane.nx[COORD_W-1] ? neg_x_reg : pos_x_reg;
    assign op_y = plane.ny[COORD_W-1] ? neg_y_reg : pos_y_reg;
    assign op_z = plane.nz[COORD_W-1] ? neg_z_reg : pos_z_reg;

    always_ff @(posedge aclk) begin
        p_x_reg   <= plane.nx * op_x;
        p_y_reg   <= plane.ny * op_y;
        p_z_reg   <= plane.nz * op_z;
        off_reg   <= OFF_W'(plane.d) + bias_reg;
        sum_a_reg <= (PROD_W+1)'(p_x_reg) + (PROD_W+1)'(p_y_reg);
        sum_b_reg <= (PROD_W+1)'(p_z_reg) + (PROD_W+1)'($signed({off_reg, 16'h0000}));
    end

    assign total  = (PROD_W+2)'(sum_a_reg) + (PROD_W+2)'(sum_b_reg);
    assign culled = total[PROD_W+1] || (box_reg && total == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            last0_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            last1_reg   <= 1'b0;
            v2_reg      <= 1'b0;
            last2_reg   <= 1'b0;
            done_reg    <= 1'b0;
            visible_reg <= 1'b1;
        end else begin
            v0_reg    <= ctrl.issue;
            last0_reg <= ctrl.issue && ctrl.last;
            v1_reg    <= v0_reg;
            last1_reg <= last0_reg;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            done_reg  <= v2_reg && last2_reg;
            if (ctrl.start) begin
                visible_reg <= 1'b1;
            end else if (v2_reg && culled) begin
                visible_reg <= 1'b0;
            end
        end
    end

    assign stat.done    = done_reg;
    assign stat.visible = visible_reg;

endmodule

@@ design/plane_set_culling_tester.sv @@
// Clear and append words give no result.
// A test word with N stored planes occupies the block while its planes are read
// in turn and checked, and longer while the previous result waits on m_ready;
// with an empty list it goes straight to the output.
// Reset is synchronous and active low; it empties the plane list, and the
// plane memory itself is not cleared.
module plane_set_culling_tester #(
    parameter int MAX_PLANES = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_op,
    input  logic signed [pscull_pkg::COORD_W-1:0] s_a_x,
    input  logic signed [pscull_pkg::COORD_W-1:0] s_a_y,
    input  logic signed [pscull_pkg::COORD_W-1:0] s_a_z,
    input  logic signed [pscull_pkg::COORD_W-1:0] s_b_x,
    input  logic signed [pscull_pkg::COORD_W-1:0] s_b_y,
    input  logic signed [pscull_pkg::COORD_W-1:0] s_b_z,
    input  logic signed [pscull_pkg::COORD_W-1:0] s_scalar,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_visible,
    output logic                                  m_query_kind
);
    import pscull_pkg::*;

    localparam int ADDR_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CNT_W  = $clog2(MAX_PLANES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic              kind_reg, kind_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_visible_reg, m_visible_next;
    logic              m_kind_reg, m_kind_next;

    logic       accept;
    logic       out_free;
    logic       mem_we;
    plane_t     wdata;
    plane_t     rdata;
    dist_ctrl_t ctrl;
    dist_stat_t stat;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign wdata.nx = s_a_x;
    assign wdata.ny = s_a_y;
    assign wdata.nz = s_a_z;
    assign wdata.d  = s_scalar;
    assign mem_we   = accept && s_op == OP_APPEND && count_reg < CNT_W'(MAX_PLANES);

    assign ctrl.start = accept && (s_op == OP_SPHERE || s_op == OP_BOX);
    assign ctrl.issue = (state_reg == ST_RUN);
    assign ctrl.last  = (CNT_W'(rd_addr_reg) == count_reg - CNT_W'(1));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_addr_next   = rd_addr_reg;
        kind_next      = kind_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_visible_next = m_visible_reg;
        m_kind_next    = m_kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_APPEND: begin
                            if (mem_we) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default: begin
                            kind_next    = (s_op == OP_BOX);
                            rd_addr_next = '0;
                            state_next   = (count_reg == '0) ? ST_FLUSH : ST_RUN;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                rd_addr_next = rd_addr_reg + ADDR_W'(1);
                if (ctrl.last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (stat.done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_visible_next = stat.visible;
                    m_kind_next    = kind_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        rd_addr_reg   <= rd_addr_next;
        kind_reg      <= kind_next;
        m_visible_reg <= m_visible_next;
        m_kind_reg    <= m_kind_next;
    end

    pscull_plane_mem #(
        .DEPTH  (MAX_PLANES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .re    (ctrl.issue),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    pscull_dist_unit u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .box     (s_op == OP_BOX),
        .a_x     (s_a_x),
        .a_y     (s_a_y),
        .a_z     (s_a_z),
        .b_x     (s_b_x),
        .b_y     (s_b_y),
        .b_z     (s_b_z),
        .scalar  (s_scalar),
        .plane   (rdata),
        .stat    (stat)
    );

    assign m_valid      = m_valid_reg;
    assign m_visible    = m_visible_reg;
    assign m_query_kind = m_kind_reg;

endmodule
